// File: src/ldl_pkg.sv
// ----------------------------------------------------------------------------
// ldl_pkg: shared types and constants for the Levinson-Durbin LPC block
// Fixed widths, Q8.23 constants, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package ldl_pkg;

  localparam int DATA_W    = 32;
  localparam int ORDER_W   = 5;
  localparam int INDEX_W   = 5;
  localparam int FRAC_W    = 23;
  localparam int ACC_W     = 48;
  localparam int E_W       = 31;
  localparam int Q_W       = 31;
  localparam int DIV_STEPS = 31;

  localparam logic [ORDER_W-1:0]       ORDER_RESET = 5'd6;
  localparam logic signed [DATA_W-1:0] ONE_Q23     = 32'sh0080_0000;
  localparam logic signed [DATA_W-1:0] SAT_POS     = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_NEG     = 32'sh8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_STAGE,
    ST_MAC,
    ST_MAC_WAIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_KSET,
    ST_E_SQ,
    ST_E_MUL,
    ST_E_SET,
    ST_UPD,
    ST_UPD_WAIT,
    ST_KWR,
    ST_EM_RD,
    ST_EM_LD
  } ldl_state_t;

  typedef struct packed {
    logic cfg_wr;
    logic lag_wr;
    logic init;
    logic acc_clr;
    logic mac_rd;
    logic div_init;
    logic div_step;
    logic k_set;
    logic e_sq;
    logic e_mul;
    logic e_set;
    logic upd_rd;
    logic k_wr;
    logic em_rd;
    logic out_load;
  } ldl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic r0_pos;
    logic e_zero;
    logic out_free;
  } ldl_sts_t;

endpackage

// File: src/ldl_ifs.sv
// ----------------------------------------------------------------------------
// ldl_ifs: stream channels of the Levinson-Durbin LPC block
// Valid/ready channels for configuration, autocorrelation lags and coefficients.
// ----------------------------------------------------------------------------
interface ldl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ldl_pkg::ORDER_W-1:0]      lpc_order;

  modport source (output valid, output lpc_order, input ready);
  modport sink   (input valid, input lpc_order, output ready);
endinterface

interface ldl_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ldl_pkg::DATA_W-1:0] autocorr_value;

  modport source (output valid, output autocorr_value, input ready);
  modport sink   (input valid, input autocorr_value, output ready);
endinterface

interface ldl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ldl_pkg::DATA_W-1:0] coeff_value;
  logic [ldl_pkg::INDEX_W-1:0]      coeff_index;
  logic                             last_coeff;
  logic                             unstable;

  modport source (output valid, output coeff_value, output coeff_index,
                  output last_coeff, output unstable, input ready);
  modport sink   (input valid, input coeff_value, input coeff_index,
                  input last_coeff, input unstable, output ready);
endinterface

// File: src/ldl_ctrl.sv
// ----------------------------------------------------------------------------
// ldl_ctrl: sequencer of the Levinson-Durbin recursion
// Counts lags, walks stages, MAC, division, error update, row update and output.
// ----------------------------------------------------------------------------
module ldl_ctrl #(
  parameter int MAX_ORDER = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   cfg_valid,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         p_eff,
  input  ldl_pkg::ldl_sts_t                      sts,
  output ldl_pkg::ldl_cmd_t                      cmd,
  output logic [$clog2(MAX_ORDER+1)-1:0]         ra_idx,
  output logic [$clog2(MAX_ORDER+1)-1:0]         rb_idx,
  output logic [$clog2(MAX_ORDER+1)-1:0]         lag_ridx,
  output logic [$clog2(MAX_ORDER+1)-1:0]         lag_widx,
  output logic [$clog2(MAX_ORDER+1)-1:0]         stage_idx
);

  localparam int IW = $clog2(MAX_ORDER + 1);
  localparam int CW = $clog2(ldl_pkg::DIV_STEPS);

  ldl_pkg::ldl_state_t state, state_next;
  logic [IW-1:0] i, i_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] lags, lags_next;
  logic [CW-1:0] dcnt, dcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldl_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      lags  <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      lags  <= lags_next;
      dcnt  <= dcnt_next;
    end
  end

  assign lag_widx  = (lags > p_eff) ? '0 : lags;
  assign ra_idx    = (state == ldl_pkg::ST_UPD) ? IW'(i - j) : j;
  assign rb_idx    = j;
  assign lag_ridx  = IW'(i - j);
  assign stage_idx = i;

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    lags_next  = lags;
    dcnt_next  = dcnt;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.cfg_wr = cfg_valid;
    case (state)
      ldl_pkg::ST_IDLE: begin
        in_ready = !cfg_valid;
        if (cfg_valid) begin
          lags_next = '0;
        end else if (in_valid) begin
          cmd.lag_wr = 1'b1;
          if (lag_widx == p_eff) begin
            lags_next  = '0;
            state_next = ldl_pkg::ST_INIT;
          end else begin
            lags_next = IW'(lag_widx + 1'b1);
          end
        end
      end
      ldl_pkg::ST_INIT: begin
        cmd.init = 1'b1;
        if (!sts.r0_pos) begin
          j_next     = '0;
          state_next = ldl_pkg::ST_EM_RD;
        end else begin
          i_next     = IW'(1);
          state_next = ldl_pkg::ST_STAGE;
        end
      end
      ldl_pkg::ST_STAGE: begin
        cmd.acc_clr = 1'b1;
        j_next      = '0;
        state_next  = ldl_pkg::ST_MAC;
      end
      ldl_pkg::ST_MAC: begin
        cmd.mac_rd = 1'b1;
        if (j == IW'(i - 1'b1)) begin
          state_next = ldl_pkg::ST_MAC_WAIT;
        end else begin
          j_next = IW'(j + 1'b1);
        end
      end
      ldl_pkg::ST_MAC_WAIT: begin
        if (!sts.pipe_busy) begin
          state_next = ldl_pkg::ST_DIV_INIT;
        end
      end
      ldl_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = ldl_pkg::ST_DIV;
      end
      ldl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (dcnt == CW'(ldl_pkg::DIV_STEPS - 1)) begin
          state_next = ldl_pkg::ST_KSET;
        end else begin
          dcnt_next = CW'(dcnt + 1'b1);
        end
      end
      ldl_pkg::ST_KSET: begin
        cmd.k_set  = 1'b1;
        state_next = ldl_pkg::ST_E_SQ;
      end
      ldl_pkg::ST_E_SQ: begin
        cmd.e_sq   = 1'b1;
        state_next = ldl_pkg::ST_E_MUL;
      end
      ldl_pkg::ST_E_MUL: begin
        cmd.e_mul  = 1'b1;
        state_next = ldl_pkg::ST_E_SET;
      end
      ldl_pkg::ST_E_SET: begin
        cmd.e_set = 1'b1;
        if (i == IW'(1)) begin
          state_next = ldl_pkg::ST_KWR;
        end else begin
          j_next     = IW'(1);
          state_next = ldl_pkg::ST_UPD;
        end
      end
      ldl_pkg::ST_UPD: begin
        cmd.upd_rd = 1'b1;
        if (j == IW'(i - 1'b1)) begin
          state_next = ldl_pkg::ST_UPD_WAIT;
        end else begin
          j_next = IW'(j + 1'b1);
        end
      end
      ldl_pkg::ST_UPD_WAIT: begin
        if (!sts.pipe_busy) begin
          state_next = ldl_pkg::ST_KWR;
        end
      end
      ldl_pkg::ST_KWR: begin
        cmd.k_wr = 1'b1;
        if (sts.e_zero || i == p_eff) begin
          j_next     = '0;
          state_next = ldl_pkg::ST_EM_RD;
        end else begin
          i_next     = IW'(i + 1'b1);
          state_next = ldl_pkg::ST_STAGE;
        end
      end
      ldl_pkg::ST_EM_RD: begin
        cmd.em_rd  = 1'b1;
        state_next = ldl_pkg::ST_EM_LD;
      end
      ldl_pkg::ST_EM_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (j == p_eff) begin
            state_next = ldl_pkg::ST_IDLE;
          end else begin
            j_next     = IW'(j + 1'b1);
            state_next = ldl_pkg::ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ldl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/ldl_datapath.sv
// ----------------------------------------------------------------------------
// ldl_datapath: storage and arithmetic of the Levinson-Durbin recursion
// Lag and row memories, shared multiplier, accumulator, serial divider, output.
// ----------------------------------------------------------------------------
module ldl_datapath #(
  parameter int MAX_ORDER = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ldl_pkg::ldl_cmd_t                      cmd,
  output ldl_pkg::ldl_sts_t                      sts,
  input  logic [ldl_pkg::ORDER_W-1:0]            cfg_order,
  input  logic signed [ldl_pkg::DATA_W-1:0]      lag_value,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         ra_idx,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         rb_idx,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         lag_ridx,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         lag_widx,
  input  logic [$clog2(MAX_ORDER+1)-1:0]         stage_idx,
  output logic [$clog2(MAX_ORDER+1)-1:0]         p_eff,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ldl_pkg::DATA_W-1:0]      coeff_value,
  output logic [ldl_pkg::INDEX_W-1:0]            coeff_index,
  output logic                                   last_coeff,
  output logic                                   unstable
);

  localparam int IW  = $clog2(MAX_ORDER + 1);
  localparam int DW  = ldl_pkg::DATA_W;
  localparam int AW  = ldl_pkg::ACC_W;
  localparam int EW  = ldl_pkg::E_W;
  localparam int QW  = ldl_pkg::Q_W;
  localparam int FW  = ldl_pkg::FRAC_W;
  localparam int XW  = ldl_pkg::INDEX_W;
  localparam int TW  = 2 * DW - FW;

  logic signed [DW-1:0] lag_mem [MAX_ORDER+1];
  logic signed [DW-1:0] row_mem [2][MAX_ORDER+1];

  logic [ldl_pkg::ORDER_W-1:0] order;
  logic signed [DW-1:0] r0;
  logic signed [DW-1:0] lag_q, a_mem_q, b_mem_q, b2;
  logic                 a_one_q;
  logic signed [DW-1:0] a_val, mul_b;
  logic                 v1, v2, m1, m2;
  logic [IW-1:0]        w1, w2;
  logic signed [2*DW-1:0] prod;
  logic signed [TW-1:0] term;
  logic signed [TW:0]   upd_sum;
  logic signed [DW-1:0] upd_sat;
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        acc_mag;
  logic [EW-1:0]        e;
  logic [EW-1:0]        rem;
  logic [EW:0]          rem2;
  logic                 div_ge;
  logic [QW-1:0]        num_lo, q;
  logic                 neg_q, sat_q;
  logic signed [DW-1:0] k;
  logic                 kbig;
  logic [FW-1:0]        klow;
  logic [2*FW-1:0]      k2;
  logic [2*FW:0]        fac_full;
  logic [EW+FW:0]       eprod;
  logic                 bank, bad;
  logic [IW-1:0]        top;
  logic                 em_mask_q, em_last_q;
  logic [IW-1:0]        em_idx_q;

  always_comb begin
    if (order == '0) begin
      p_eff = IW'(1);
    end else if (int'(order) > MAX_ORDER) begin
      p_eff = IW'(MAX_ORDER);
    end else begin
      p_eff = IW'(order);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ldl_pkg::ORDER_RESET;
    end else if (cmd.cfg_wr) begin
      order <= cfg_order;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lag_wr) begin
      lag_mem[lag_widx] <= lag_value;
    end
    if (cmd.mac_rd) begin
      lag_q <= lag_mem[lag_ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lag_wr && lag_widx == '0) begin
      r0 <= lag_value;
    end
  end

  assign sts.r0_pos = !r0[DW-1] && (r0 != '0);

  always_ff @(posedge clk) begin
    if (v2 && m2) begin
      row_mem[!bank][w2] <= upd_sat;
    end else if (cmd.k_wr) begin
      row_mem[!bank][stage_idx] <= k;
    end
    if (cmd.mac_rd || cmd.upd_rd || cmd.em_rd) begin
      a_mem_q <= row_mem[bank][ra_idx];
      a_one_q <= (ra_idx == '0);
    end
    if (cmd.upd_rd) begin
      b_mem_q <= row_mem[bank][rb_idx];
    end
  end

  assign a_val = a_one_q ? ldl_pkg::ONE_Q23 : a_mem_q;
  assign mul_b = m1 ? k : lag_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_rd || cmd.upd_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    m1   <= cmd.upd_rd;
    w1   <= rb_idx;
    m2   <= m1;
    w2   <= w1;
    b2   <= b_mem_q;
    prod <= a_val * mul_b;
  end

  assign sts.pipe_busy = v1 || v2;

  assign term    = prod[2*DW-1:FW];
  assign upd_sum = {b2[DW-1], b2} + {{(TW+1-DW){1'b0}}, {DW{1'b0}}} +
                   {term[TW-1], term} - {{(TW+1-DW){1'b0}}, {DW{1'b0}}} +
                   {{(TW+1-DW){b2[DW-1]}}, b2} - {b2[DW-1], b2};

  always_comb begin
    if (upd_sum > (TW+1)'(ldl_pkg::SAT_POS)) begin
      upd_sat = ldl_pkg::SAT_POS;
    end else if (upd_sum < (TW+1)'(ldl_pkg::SAT_NEG)) begin
      upd_sat = ldl_pkg::SAT_NEG;
    end else begin
      upd_sat = upd_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (v2 && !m2) begin
      acc <= acc + AW'(term);
    end
  end

  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign rem2    = {rem, num_lo[QW-1]};
  assign div_ge  = rem2 >= {1'b0, e};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_q  <= !acc[AW-1] && (acc != '0);
      sat_q  <= acc_mag >= AW'({e, 8'b0});
      rem    <= acc_mag[EW+7:8];
      num_lo <= {acc_mag[7:0], {FW{1'b0}}};
      q      <= '0;
    end else if (cmd.div_step) begin
      rem    <= div_ge ? EW'(rem2 - {1'b0, e}) : rem2[EW-1:0];
      q      <= {q[QW-2:0], div_ge};
      num_lo <= {num_lo[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.k_set) begin
      if (sat_q) begin
        k <= neg_q ? ldl_pkg::SAT_NEG : ldl_pkg::SAT_POS;
      end else begin
        k <= neg_q ? -DW'({1'b0, q}) : DW'({1'b0, q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_set) begin
      kbig <= sat_q || (q[QW-1:FW] != '0);
      klow <= q[FW-1:0];
    end
    if (cmd.e_sq) begin
      k2 <= klow * klow;
    end
  end

  assign fac_full = {1'b1, {(2*FW){1'b0}}} - {1'b0, k2};

  always_ff @(posedge clk) begin
    if (cmd.e_mul) begin
      eprod <= e * fac_full[2*FW:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e <= '0;
    end else if (cmd.init) begin
      e <= sts.r0_pos ? r0[EW-1:0] : '0;
    end else if (cmd.e_set) begin
      e <= kbig ? '0 : eprod[EW+FW-1:FW];
    end
  end

  assign sts.e_zero = (e == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      bad  <= 1'b0;
      top  <= '0;
    end else if (cmd.init) begin
      bad <= !sts.r0_pos;
      top <= '0;
    end else if (cmd.k_wr) begin
      bank <= !bank;
      bad  <= (e == '0);
      top  <= stage_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_rd) begin
      em_mask_q <= (ra_idx > top);
      em_last_q <= (ra_idx == p_eff);
      em_idx_q  <= ra_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      coeff_value <= em_mask_q ? '0 : a_val;
      coeff_index <= XW'(em_idx_q);
      last_coeff  <= em_last_q;
      unstable    <= bad;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: src/levinson_durbin_lpc_top.sv
// ----------------------------------------------------------------------------
// levinson_durbin_lpc_top: Levinson-Durbin LPC coefficient engine
// Collects r[0..p], runs the recursion, emits p+1 Q8.23 coefficients.
// ----------------------------------------------------------------------------
//  channel     dir  item                     handshake
//  cfg         in   lpc_order                valid/ready, ready always high
//  lag_in      in   autocorr_value           valid/ready
//  coeff_out   out  coeff_value, coeff_index valid/ready
//                   last_coeff, unstable
//
//  Lags are taken in idle while cfg.valid is low; recursion starts after lag p.
//  Stages use the 31-step serial divider and the single shared multiplier (MAC,
//  row update); coefficients go out one at a time, each when coeff_out is free.
//  lag_in is held off from lag p until the last coefficient is registered.
//  Synchronous active-high reset; order resets to 6.
// ----------------------------------------------------------------------------
module levinson_durbin_lpc_top #(
  parameter int MAX_ORDER = 16
) (
  input  logic           clk,
  input  logic           rst,
  ldl_cfg_if.sink        cfg,
  ldl_in_if.sink         lag_in,
  ldl_out_if.source      coeff_out
);

  localparam int IW = $clog2(MAX_ORDER + 1);

  ldl_pkg::ldl_cmd_t cmd;
  ldl_pkg::ldl_sts_t sts;
  logic [IW-1:0] p_eff, ra_idx, rb_idx, lag_ridx, lag_widx, stage_idx;

  assign cfg.ready = 1'b1;

  ldl_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lag_in.valid),
    .in_ready  (lag_in.ready),
    .cfg_valid (cfg.valid),
    .p_eff     (p_eff),
    .sts       (sts),
    .cmd       (cmd),
    .ra_idx    (ra_idx),
    .rb_idx    (rb_idx),
    .lag_ridx  (lag_ridx),
    .lag_widx  (lag_widx),
    .stage_idx (stage_idx)
  );

  ldl_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_order   (cfg.lpc_order),
    .lag_value   (lag_in.autocorr_value),
    .ra_idx      (ra_idx),
    .rb_idx      (rb_idx),
    .lag_ridx    (lag_ridx),
    .lag_widx    (lag_widx),
    .stage_idx   (stage_idx),
    .p_eff       (p_eff),
    .out_valid   (coeff_out.valid),
    .out_ready   (coeff_out.ready),
    .coeff_value (coeff_out.coeff_value),
    .coeff_index (coeff_out.coeff_index),
    .last_coeff  (coeff_out.last_coeff),
    .unstable    (coeff_out.unstable)
  );

endmodule

// File: src/ldl_checker.sv
// ----------------------------------------------------------------------------
// ldl_checker: port-level checks of the Levinson-Durbin LPC block
// Output hold, leading coefficient, set framing and flag consistency.
// ----------------------------------------------------------------------------
module ldl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ldl_pkg::DATA_W-1:0] coeff_value,
  input logic [ldl_pkg::INDEX_W-1:0]       coeff_index,
  input logic                              last_coeff,
  input logic                              unstable
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(coeff_value) &&
                                   $stable(coeff_index) && $stable(unstable)))
    else $error("coefficient changed while stalled");

  a_lead_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && coeff_index == '0) |-> (coeff_value == ldl_pkg::ONE_Q23))
    else $error("leading coefficient is not one");

  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && coeff_index == '0) |-> !last_coeff)
    else $error("set ended at index zero");

  a_flag_same: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_coeff) |=>
      (!out_valid || unstable == $past(unstable)))
    else $error("unstable flag changed within a set");

endmodule

bind levinson_durbin_lpc_top ldl_checker u_ldl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (coeff_out.valid),
  .out_ready   (coeff_out.ready),
  .coeff_value (coeff_out.coeff_value),
  .coeff_index (coeff_out.coeff_index),
  .last_coeff  (coeff_out.last_coeff),
  .unstable    (coeff_out.unstable)
);
